FILE: hdl/tga_rle_indexed_decoder_defines.svh
// Assertion macros for the TGA RLE indexed decoder.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TGA_RLE_INDEXED_DECODER_DEFINES_SVH
`define TGA_RLE_INDEXED_DECODER_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define TGARLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define TGARLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tgarle_pkg.sv
// Shared types and constants of the TGA RLE indexed decoder.
// No dependencies; used by the channel interfaces and the decoder.
`timescale 1ns / 1ps

package tgarle_pkg;

  // Width of the frame buffer address registers (8 to 32).
  localparam int unsigned ADDR_BITS = 32;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIM_W      = 16;
  localparam int unsigned OUT_ADDR_W = 32;

  localparam logic [DIM_W-1:0] MIN_WIDTH = 16'd4;
  localparam logic [7:0]       MAX_RUN   = 8'd128;

  localparam logic [0:0] ACT_DATA  = 1'b0;
  localparam logic [0:0] ACT_START = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 4'd0,
    CFG_IMAGE_HEIGHT = 4'd1,
    CFG_RLE_ENABLED  = 4'd2,
    CFG_TOP_DOWN     = 4'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

endpackage

FILE: hdl/tgarle_if.sv
// Valid/ready channel interfaces of the TGA RLE indexed decoder.
// Depends on tgarle_pkg for the field widths.
`timescale 1ns / 1ps

interface tgarle_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] action;
  logic [7:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface tgarle_out_if import tgarle_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] pixel_address;
  logic [7:0]            run_length;
  logic [7:0]            pixel_value;
  logic                  image_done;
  logic                  last_of_item;

  modport source (output valid, pixel_address, run_length, pixel_value, image_done,
                  last_of_item, input ready);
  modport sink   (input valid, pixel_address, run_length, pixel_value, image_done,
                  last_of_item, output ready);
endinterface

interface tgarle_cfg_if import tgarle_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/tga_rle_indexed_decoder.sv
// TGA RLE indexed decoder: takes one byte of an 8-bit TGA pixel stream per item and
// emits write segments (address, length, value) for the frame buffer. A start item,
// an RLE header byte or a byte that arrives with no image active produces no segment.
// A pixel byte is accepted, then produces its segments one step at a time, so a raw
// or literal byte yields one segment and a repeat run yields one per row it touches;
// all segment steps go through a single shared address adder.
// The input is held off while segments are being produced, and a stalled output
// register delays each segment step, which holds the input off for that much longer.
`timescale 1ns / 1ps
`include "tga_rle_indexed_decoder_defines.svh"

module tga_rle_indexed_decoder
  import tgarle_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  tgarle_cfg_if.sink     cfg_i,
  tgarle_in_if.sink      in_i,
  tgarle_out_if.source   out_o
);

  // configuration
  logic [DIM_W-1:0] width_q, height_q;
  logic             rle_q, top_down_q;

  // control state
  state_e                state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [7:0]            packet_left_q, packet_left_d;
  logic [DIM_W-1:0]      cols_q, cols_d;
  logic [DIM_W-1:0]      rows_q, rows_d;
  logic [ADDR_BITS-1:0]  row_start_q, row_start_d;
  logic [ADDR_BITS-1:0]  wr_addr_q, wr_addr_d;
  logic [7:0]            count_q, count_d;
  logic [7:0]            value_q, value_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_ADDR_W-1:0] out_addr_q;
  logic [7:0]            out_len_q, out_value_q;
  logic                  out_done_q, out_last_q;

  logic                  in_acc, step, emit_go;
  logic [DIM_W-1:0]      eff_w, h_m1, cols_cur, cols_after, rows_dec;
  logic [OUT_ADDR_W-1:0] prod;
  logic [7:0]            seg_len, count_after;
  logic                  seg_done, seg_last, row_adv;
  logic [ADDR_BITS-1:0]  add_a, add_b, add_sum;
  logic                  add_sub;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign step        = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  assign eff_w = (width_q < MIN_WIDTH) ? MIN_WIDTH : width_q;
  assign h_m1  = height_q - 16'd1;
  assign prod  = OUT_ADDR_W'(h_m1) * OUT_ADDR_W'(eff_w);

  // segment of the current run that fits into the current row
  assign cols_cur    = (cols_q == '0) ? eff_w : cols_q;
  assign seg_len     = ({8'd0, count_q} < cols_cur) ? count_q : cols_cur[7:0];
  assign cols_after  = cols_cur - {8'd0, seg_len};
  assign count_after = count_q - seg_len;
  assign rows_dec    = rows_q - 16'd1;
  assign seg_done    = (cols_after == '0) && (rows_dec == '0);
  assign row_adv     = (cols_after == '0) && (rows_dec != '0);
  assign seg_last    = (count_after == '0) || seg_done;

  // shared adder: advance within the row, or step the row start up or down
  assign add_a   = row_adv ? row_start_q : wr_addr_q;
  assign add_sub = row_adv && !top_down_q;
  assign add_b   = row_adv ? ADDR_BITS'(eff_w) : ADDR_BITS'(seg_len);
  assign add_sum = add_a + (add_b ^ {ADDR_BITS{add_sub}}) + ADDR_BITS'(add_sub);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (emit_go) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (step && seg_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and packet tracking
  always_comb begin
    phase_d       = phase_q;
    packet_left_d = packet_left_q;
    cols_d        = cols_q;
    rows_d        = rows_q;
    row_start_d   = row_start_q;
    wr_addr_d     = wr_addr_q;
    count_d       = count_q;
    value_d       = value_q;
    emit_go       = 1'b0;

    if (in_acc) begin
      if (in_i.action == ACT_START) begin
        cols_d        = eff_w;
        rows_d        = height_q;
        row_start_d   = (top_down_q || height_q == '0) ? '0 : ADDR_BITS'(prod);
        wr_addr_d     = row_start_d;
        phase_d       = PH_HEADER;
        packet_left_d = '0;
      end else if (rows_q != '0) begin
        value_d = in_i.data_byte;
        if (!rle_q) begin
          count_d = 8'd1;
          emit_go = 1'b1;
        end else begin
          case (phase_q)
            PH_REPEAT: begin
              count_d       = packet_left_q;
              emit_go       = (packet_left_q != '0);
              packet_left_d = '0;
              phase_d       = PH_HEADER;
            end
            PH_LITERAL: begin
              count_d       = 8'd1;
              emit_go       = 1'b1;
              packet_left_d = packet_left_q - 8'd1;
              if (packet_left_d == '0) phase_d = PH_HEADER;
            end
            default: begin
              // header byte: bit 7 selects a repeat run
              packet_left_d = {1'b0, in_i.data_byte[6:0]} + 8'd1;
              phase_d       = in_i.data_byte[7] ? PH_REPEAT : PH_LITERAL;
            end
          endcase
        end
      end
    end

    if (step) begin
      count_d   = count_after;
      wr_addr_d = add_sum;
      if (cols_after == '0) begin
        rows_d = rows_dec;
        if (row_adv) begin
          row_start_d = add_sum;
          cols_d      = eff_w;
        end else begin
          cols_d = cols_after;
        end
      end else begin
        cols_d = cols_after;
      end
    end
  end

  assign out_valid_d = step ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= MIN_WIDTH;
      height_q      <= 16'd1;
      rle_q         <= 1'b0;
      top_down_q    <= 1'b0;
      state_q       <= ST_IDLE;
      phase_q       <= PH_HEADER;
      packet_left_q <= '0;
      cols_q        <= '0;
      rows_q        <= '0;
      row_start_q   <= '0;
      wr_addr_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_IMAGE_WIDTH:  width_q    <= cfg_i.data;
          CFG_IMAGE_HEIGHT: height_q   <= cfg_i.data;
          CFG_RLE_ENABLED:  rle_q      <= cfg_i.data[0];
          CFG_TOP_DOWN:     top_down_q <= cfg_i.data[0];
          default: ;
        endcase
      end
      state_q       <= state_d;
      phase_q       <= phase_d;
      packet_left_q <= packet_left_d;
      cols_q        <= cols_d;
      rows_q        <= rows_d;
      row_start_q   <= row_start_d;
      wr_addr_q     <= wr_addr_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    value_q <= value_d;
    if (step) begin
      out_addr_q  <= OUT_ADDR_W'(wr_addr_q);
      out_len_q   <= seg_len;
      out_value_q <= value_q;
      out_done_q  <= seg_done;
      out_last_q  <= seg_last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_address = out_addr_q;
  assign out_o.run_length    = out_len_q;
  assign out_o.pixel_value   = out_value_q;
  assign out_o.image_done    = out_done_q;
  assign out_o.last_of_item  = out_last_q;

  `TGARLE_ASSERT_NOW(a_emit_live, state_q == ST_EMIT,
    rows_q != '0 && count_q != '0, "emit with nothing left to write")
  `TGARLE_ASSERT_NOW(a_len_range, out_valid_q,
    out_len_q != '0 && out_len_q <= MAX_RUN, "segment length out of range")
  `TGARLE_ASSERT_NOW(a_done_last, out_valid_q && out_done_q,
    out_last_q, "image end not marked as last segment")
  `TGARLE_ASSERT_NEXT(a_last_idle, step && seg_last,
    state_q == ST_IDLE && out_valid_q && out_last_q, "last segment did not release the input")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for tga_rle_indexed_decoder: directed and random byte streams
// in raw and RLE mode, with every segment checked against an in-bench decoder model.
// Depends on tgarle_pkg and the channel interfaces in tgarle_if.sv.
`timescale 1ns / 1ps

module tb_top;
  import tgarle_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam int unsigned RANDOM_ITEMS  = 420;
  localparam logic [31:0] ADDR_MASK     = 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd9;

  typedef struct packed {
    logic [0:0] action;
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] pixel_address;
    logic [7:0]            run_length;
    logic [7:0]            pixel_value;
    logic                  image_done;
    logic                  last_of_item;
  } segment_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tgarle_in_if  in_if ();
  tgarle_out_if out_if ();
  tgarle_cfg_if cfg_if ();

  tga_rle_indexed_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  byte_item_t byte_queue[$];
  segment_t   pending_segments[$];
  bit         no_gaps = 1'b0;

  int unsigned items_accepted = 0;
  int unsigned random_items   = 0;
  int unsigned segments_seen  = 0;
  int unsigned images_done    = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;

  // Register mirror and decoder state
  logic [15:0] img_width  = 16'd4;
  logic [15:0] img_height = 16'd1;
  logic        rle_mode   = 1'b0;
  logic        top_down_mode = 1'b0;
  phase_e      pkt_phase  = PH_HEADER;
  logic [7:0]  pkt_left   = '0;
  logic [15:0] cols_left  = '0;
  logic [15:0] rows_left  = '0;
  logic [31:0] row_base   = '0;
  logic [31:0] wr_addr    = '0;

  function automatic logic [15:0] row_pixels();
    return (img_width < MIN_WIDTH) ? MIN_WIDTH : img_width;
  endfunction

  // Split a run of one value into row-bounded segments; returns how many were queued.
  function automatic int paint_run(input int unsigned count, input logic [7:0] value);
    segment_t    seg;
    logic [15:0] len;
    logic [15:0] w;
    int          n;
    n = 0;
    while (count != 0 && rows_left != 0) begin
      if (cols_left == 0) cols_left = row_pixels();
      len = (count < cols_left) ? 16'(count) : cols_left;
      seg.pixel_address = wr_addr & ADDR_MASK;
      seg.run_length    = len[7:0];
      seg.pixel_value   = value;
      seg.image_done    = 1'b0;
      seg.last_of_item  = 1'b0;
      wr_addr   = (wr_addr + 32'(len)) & ADDR_MASK;
      cols_left = cols_left - len;
      count     = count - 32'(len);
      if (cols_left == 0) begin
        rows_left = rows_left - 16'd1;
        if (rows_left == 0) begin
          seg.image_done = 1'b1;
        end else begin
          w = row_pixels();
          if (top_down_mode) row_base = (row_base + 32'(w)) & ADDR_MASK;
          else row_base = (row_base - 32'(w)) & ADDR_MASK;
          wr_addr   = row_base;
          cols_left = w;
        end
      end
      pending_segments.push_back(seg);
      n++;
    end
    return n;
  endfunction

  function automatic void decode_byte(input byte_item_t it);
    logic [15:0] w;
    int          n;
    n = 0;
    if (it.action == ACT_START) begin
      w = row_pixels();
      cols_left = w;
      rows_left = img_height;
      if (top_down_mode || img_height == 0) row_base = '0;
      else row_base = 32'((64'(img_height) - 64'd1) * 64'(w)) & ADDR_MASK;
      wr_addr   = row_base;
      pkt_phase = PH_HEADER;
      pkt_left  = '0;
    end else if (rows_left != 0) begin
      if (!rle_mode) begin
        n = paint_run(1, it.data_byte);
      end else begin
        case (pkt_phase)
          PH_REPEAT: begin
            n = paint_run(32'(pkt_left), it.data_byte);
            pkt_left  = '0;
            pkt_phase = PH_HEADER;
          end
          PH_LITERAL: begin
            n = paint_run(1, it.data_byte);
            pkt_left = pkt_left - 8'd1;
            if (pkt_left == 0) pkt_phase = PH_HEADER;
          end
          default: begin
            pkt_left  = {1'b0, it.data_byte[6:0]} + 8'd1;
            pkt_phase = it.data_byte[7] ? PH_REPEAT : PH_LITERAL;
          end
        endcase
      end
    end
    if (n > 0) pending_segments[pending_segments.size() - 1].last_of_item = 1'b1;
  endfunction

  // Byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.action    <= ACT_DATA;
      in_if.data_byte <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(byte_queue.pop_front());
        items_accepted++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered item
      end else if (byte_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 14)) begin
        in_if.valid     <= 1'b1;
        in_if.action    <= byte_queue[0].action;
        in_if.data_byte <= byte_queue[0].data_byte;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Segment monitor
  always @(posedge clk_i or negedge rst_ni) begin : seg_mon
    segment_t got;
    segment_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.pixel_address = out_if.pixel_address;
        got.run_length    = out_if.run_length;
        got.pixel_value   = out_if.pixel_value;
        got.image_done    = out_if.image_done;
        got.last_of_item  = out_if.last_of_item;
        segments_seen++;
        if (got.image_done === 1'b1) images_done++;
        if (pending_segments.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected segment addr %h len %0d value %h done %b last %b",
                     $realtime, got.pixel_address, got.run_length, got.pixel_value,
                     got.image_done, got.last_of_item);
        end else begin
          want = pending_segments.pop_front();
          if (got.pixel_address !== want.pixel_address || got.run_length !== want.run_length ||
              got.pixel_value !== want.pixel_value || got.image_done !== want.image_done ||
              got.last_of_item !== want.last_of_item) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: segment %0d expected addr %h len %0d value %h done %b last %b",
                       $realtime, segments_seen, want.pixel_address, want.run_length,
                       want.pixel_value, want.image_done, want.last_of_item);
              $display("%0t: segment %0d actual   addr %h len %0d value %h done %b last %b",
                       $realtime, segments_seen, got.pixel_address, got.run_length,
                       got.pixel_value, got.image_done, got.last_of_item);
            end
          end
        end
      end
      out_if.ready <= no_gaps || ($urandom_range(99) >= 14);
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d stalled cycles, %0d segments outstanding",
               idle_cycles, pending_segments.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_item_t it;
    it.action    = ACT_DATA;
    it.data_byte = b;
    byte_queue.push_back(it);
    random_items++;
  endtask

  task automatic push_start();
    byte_item_t it;
    it.action    = ACT_START;
    it.data_byte = 8'($urandom_range(255));
    byte_queue.push_back(it);
    random_items++;
  endtask

  // Wait until the decoder has drained, then give it time to finish any header work.
  task automatic settle();
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || in_if.valid || pending_segments.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_width     = val;
      CFG_IMAGE_HEIGHT: img_height    = val;
      CFG_RLE_ENABLED:  rle_mode      = val[0];
      CFG_TOP_DOWN:     top_down_mode = val[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] flag_word(input logic bit0);
    return {15'($urandom_range(32767)), bit0};
  endfunction

  function automatic logic [6:0] pick_count(input bit repeat_run);
    int unsigned r;
    r = $urandom_range(99);
    if (repeat_run) begin
      if (r < 60) return 7'($urandom_range(7));
      if (r < 90) return 7'($urandom_range(40, 8));
      return 7'($urandom_range(127, 41));
    end
    if (r < 75) return 7'($urandom_range(5));
    if (r < 95) return 7'($urandom_range(20, 6));
    return 7'($urandom_range(63, 21));
  endfunction

  task automatic random_image();
    int unsigned r;
    int unsigned w;
    int unsigned h;
    int unsigned pix;
    int unsigned budget;
    int unsigned used;
    int unsigned cnt;
    bit          tweak;
    bit          rep;
    settle();
    r = $urandom_range(99);
    if (r < 8) w = $urandom_range(3);
    else if (r < 88) w = $urandom_range(12, 4);
    else if (r < 97) w = $urandom_range(300, 13);
    else w = 65535;
    r = $urandom_range(99);
    if (r < 5) h = 0;
    else if (r < 95) h = $urandom_range(5, 1);
    else h = $urandom_range(65535, 6);
    write_reg(CFG_IMAGE_WIDTH, 16'(w));
    write_reg(CFG_IMAGE_HEIGHT, 16'(h));
    write_reg(CFG_RLE_ENABLED, flag_word($urandom_range(2) != 0));
    write_reg(CFG_TOP_DOWN, flag_word(1'($urandom_range(1))));
    push_start();
    pix    = ((w < 4) ? 4 : w) * h;
    budget = $urandom_range(40, 8);
    tweak  = ($urandom_range(9) == 0);
    used   = 0;
    if (!rle_mode) begin
      if (pix < budget) budget = pix + $urandom_range(2);
      while (used < budget) begin
        if ($urandom_range(49) == 0) push_start();
        else push_byte(8'($urandom_range(255)));
        used++;
      end
    end else begin
      while (used < budget) begin
        r = $urandom_range(99);
        if (tweak && used >= budget / 2) begin
          // change a register halfway through an image
          tweak = 1'b0;
          settle();
          case ($urandom_range(3))
            0: write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(12)));
            1: write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(6)));
            2: write_reg(CFG_RLE_ENABLED, flag_word(1'($urandom_range(1))));
            default: write_reg(CFG_TOP_DOWN, flag_word(1'($urandom_range(1))));
          endcase
        end
        if (r < 85) begin
          rep = 1'($urandom_range(1));
          cnt = 32'(pick_count(rep));
          push_byte({rep, 7'(cnt)});
          if (rep) begin
            push_byte(8'($urandom_range(255)));
            used += 2;
          end else begin
            repeat (cnt + 1) push_byte(8'($urandom_range(255)));
            used += cnt + 2;
          end
        end else if (r < 96) begin
          push_byte(8'($urandom_range(255)));
          used++;
        end else begin
          push_start();
          used++;
        end
      end
    end
  endtask

  initial begin
    int unsigned img_count;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_DATA;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_IMAGE_WIDTH;
    cfg_if.data     = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset values: no image yet, then a four pixel raw row, then a trailing byte
    push_byte(8'h3C);
    push_start();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    push_byte(8'hA5);
    push_byte(8'h99);
    settle();

    // Narrow width taken as four; literal pair then a 128 pixel repeat over many rows
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd40);
    write_reg(CFG_RLE_ENABLED, 16'h0001);
    write_reg(CFG_TOP_DOWN, 16'h0000);
    write_reg(CFG_SPARE_IDX, 16'hFFFF);
    push_start();
    push_byte(8'h01);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h80);
    push_byte(8'h7F);
    settle();

    // Widen mid-image so the bottom-up row step wraps the address
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    push_byte(8'h81);
    push_byte(8'hC3);
    settle();
    write_reg(CFG_TOP_DOWN, 16'hFFFF);
    push_byte(8'h02);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h03);
    settle();

    // Zero height ignores data; then the largest image
    write_reg(CFG_IMAGE_HEIGHT, 16'd0);
    push_start();
    push_byte(8'h42);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(CFG_TOP_DOWN, 16'h0000);
    push_start();
    push_byte(8'hFF);
    push_byte(8'h55);

    random_items = 0;
    img_count    = 0;
    while (random_items < RANDOM_ITEMS) begin
      no_gaps = (img_count >= 6 && img_count < 10);
      random_image();
      img_count++;
    end
    no_gaps = 1'b0;

    settle();
    repeat (20) @(negedge clk_i);
    $display("covered %0d input items in %0d random images, %0d register writes",
             items_accepted, img_count, reg_writes);
    $display("checked %0d segments, %0d finished images, %0d mismatches",
             segments_seen, images_done, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: tga_rle_indexed_decoder.f
+incdir+hdl
hdl/tgarle_pkg.sv
hdl/tgarle_if.sv
hdl/tga_rle_indexed_decoder.sv
bench/tb_top.sv
